@@ sv/psrst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrst_pkg
// Shared types and constants for the point-set range-sum table.
// ----------------------------------------------------------------------------
package psrst_pkg;

  localparam int DATA_W          = 64;
  localparam int POS_W           = 11;
  localparam int ENTRY_COUNT_W   = 11;
  localparam int DEF_MAX_ENTRIES = 1024;

  localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RESET = ENTRY_COUNT_W'(1024);

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_HI,
    ST_QRY_LO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_we;
    logic ent_we;
    logic upd_we;
    logic walk_step;
    logic walk_sub;
    logic lo_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic set_ok;
    logic clr_last;
    logic upd_last;
    logic k_zero;
  } dp_status_t;

endpackage

@@ sv/point_set_range_sum_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_range_sum_table
// Table of signed 64-bit entries with Fenwick partial sums for range sums.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. A set command
// writes one entry and walks the partial-sum update path, each node being a
// read followed by a write on the partial-sum memory; it visits at most
// log2(MAX_ENTRIES) + 1 nodes and gives no result. A set outside the table
// in use is dropped at once. A query walks the prefix paths of the clipped
// last position and of the position just below the clipped first one, one
// partial-sum read a cycle, and busy stays high through both walks and the
// output state; its sum is shown on out_range_total for one cycle with
// out_valid. The receiver cannot stall the result, and the next command
// is taken in the cycle after it. The entry count register is written through
// cfg_write_en; the user must write it only while the block is idle, which
// the block itself does not enforce. After reset both memories are cleared
// in a pass over all MAX_ENTRIES addresses, during which busy is high and
// the entry count may still be written.
// ----------------------------------------------------------------------------
module point_set_range_sum_table
  import psrst_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write_en,
  input  logic [ENTRY_COUNT_W-1:0] cfg_entry_count,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_new_value,
  input  logic [POS_W-1:0]         in_range_first,
  input  logic [POS_W-1:0]         in_range_last,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_range_total
);

  dp_cmd_t    cmd;
  dp_status_t status;

  psrst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  psrst_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_write_en    (cfg_write_en),
    .cfg_entry_count (cfg_entry_count),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_new_value    (in_new_value),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .out_range_total (out_range_total)
  );

endmodule

@@ sv/psrst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psrst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/psrst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrst_ctrl
// Sequencer for the clearing pass, point sets and range-sum queries.
// ----------------------------------------------------------------------------
module psrst_ctrl
  import psrst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (status.is_query) begin
            state_nxt = ST_QRY_HI;
          end else if (status.set_ok) begin
            state_nxt = ST_SET_RD;
          end
        end
      end
      ST_SET_RD: state_nxt = ST_SET_WR;
      ST_SET_WR: state_nxt = ST_UPD_RD;
      ST_UPD_RD: state_nxt = ST_UPD_WR;
      ST_UPD_WR: begin
        state_nxt = status.upd_last ? ST_IDLE : ST_UPD_RD;
      end
      ST_QRY_HI: begin
        if (status.k_zero) state_nxt = ST_QRY_LO;
      end
      ST_QRY_LO: begin
        if (status.k_zero) state_nxt = ST_OUT;
      end
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SET_RD: ;
      ST_SET_WR: cmd.ent_we = 1'b1;
      ST_UPD_RD: ;
      ST_UPD_WR: cmd.upd_we = 1'b1;
      ST_QRY_HI: begin
        cmd.walk_step = !status.k_zero;
        cmd.lo_load   = status.k_zero;
      end
      ST_QRY_LO: begin
        cmd.walk_step = !status.k_zero;
        cmd.walk_sub  = 1'b1;
      end
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/psrst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrst_dp
// Datapath: entry and partial-sum memories, tree walk pointers, accumulator.
// ----------------------------------------------------------------------------
module psrst_dp
  import psrst_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic                     cfg_write_en,
  input  logic [ENTRY_COUNT_W-1:0] cfg_entry_count,
  input  logic                     in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_new_value,
  input  logic [POS_W-1:0]         in_range_first,
  input  logic [POS_W-1:0]         in_range_last,
  output logic signed [DATA_W-1:0] out_range_total
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int PW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (PW > ENTRY_COUNT_W) ? PW : ENTRY_COUNT_W;

  logic [ENTRY_COUNT_W-1:0] entry_count_r;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [DATA_W-1:0]        val_r, val_nxt;
  logic [DATA_W-1:0]        delta_r, delta_nxt;
  logic [PW-1:0]            k_r, k_nxt;
  logic [PW-1:0]            lo_r, lo_nxt;
  logic [DATA_W-1:0]        acc_r, acc_nxt;
  logic                     pend_r, pend_nxt;
  logic                     sub_r, sub_nxt;
  logic [AW-1:0]            clr_cnt_r, clr_cnt_nxt;

  logic [CW-1:0] len, maxc, ec_ext, first_ext, last_ext, pos_ext, lclip, rclip;
  logic [PW:0]   pos_wide, pos_low, pos_adv;
  logic [AW-1:0] pos_addr, k_addr;

  logic              ent_we, prt_we;
  logic [AW-1:0]     ent_waddr, prt_waddr, prt_raddr;
  logic [DATA_W-1:0] ent_wdata, prt_wdata, ent_rdata, prt_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= ENTRY_COUNT_RESET;
    end else if (cfg_write_en) begin
      entry_count_r <= cfg_entry_count;
    end
  end

  always_comb begin
    maxc      = CW'(MAX_ENTRIES);
    ec_ext    = CW'(entry_count_r);
    len       = (ec_ext > maxc) ? maxc : ec_ext;
    first_ext = CW'(in_range_first);
    last_ext  = CW'(in_range_last);
    pos_ext   = CW'(in_position);
    lclip     = (first_ext == '0) ? CW'(1) : first_ext;
    rclip     = (last_ext > len) ? len : last_ext;

    pos_wide  = {1'b0, pos_r};
    pos_low   = pos_wide & (~pos_wide + (PW+1)'(1));
    pos_adv   = pos_wide + pos_low;
    pos_addr  = AW'(pos_r - PW'(1));
    k_addr    = AW'(k_r - PW'(1));
  end

  always_comb begin
    status.is_query = (in_cmd == CMD_QUERY);
    status.set_ok   = (pos_ext != '0) && (pos_ext <= len);
    status.clr_last = (clr_cnt_r == AW'(MAX_ENTRIES - 1));
    status.upd_last = (pos_adv > (PW+1)'(MAX_ENTRIES));
    status.k_zero   = (k_r == '0);
  end

  always_comb begin
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    delta_nxt   = delta_r;
    k_nxt       = k_r;
    lo_nxt      = lo_r;
    acc_nxt     = acc_r;
    pend_nxt    = cmd.walk_step;
    sub_nxt     = cmd.walk_sub;
    clr_cnt_nxt = clr_cnt_r;

    if (cmd.clr_we) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
    end

    if (cmd.load) begin
      pos_nxt = PW'(in_position);
      val_nxt = in_new_value;
      acc_nxt = '0;
      if (lclip > rclip) begin
        k_nxt  = '0;
        lo_nxt = '0;
      end else begin
        k_nxt  = PW'(rclip);
        lo_nxt = PW'(lclip - CW'(1));
      end
    end else if (pend_r) begin
      acc_nxt = sub_r ? (acc_r - prt_rdata) : (acc_r + prt_rdata);
    end

    if (cmd.ent_we) begin
      delta_nxt = val_r - ent_rdata;
    end
    if (cmd.upd_we) begin
      pos_nxt = pos_adv[PW-1:0];
    end
    if (cmd.walk_step) begin
      k_nxt = k_r & (k_r - PW'(1));
    end
    if (cmd.lo_load) begin
      k_nxt = lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      sub_r     <= 1'b0;
      clr_cnt_r <= '0;
      k_r       <= '0;
    end else begin
      pend_r    <= pend_nxt;
      sub_r     <= sub_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    delta_r <= delta_nxt;
    lo_r    <= lo_nxt;
    acc_r   <= acc_nxt;
  end

  always_comb begin
    ent_we    = cmd.clr_we || cmd.ent_we;
    ent_waddr = cmd.clr_we ? clr_cnt_r : pos_addr;
    ent_wdata = cmd.clr_we ? '0 : val_r;
    prt_we    = cmd.clr_we || cmd.upd_we;
    prt_waddr = cmd.clr_we ? clr_cnt_r : pos_addr;
    prt_wdata = cmd.clr_we ? '0 : (prt_rdata + delta_r);
    prt_raddr = cmd.walk_step ? k_addr : pos_addr;
  end

  psrst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (pos_addr),
    .rdata (ent_rdata)
  );

  psrst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_partial_ram (
    .clk   (clk),
    .we    (prt_we),
    .waddr (prt_waddr),
    .wdata (prt_wdata),
    .raddr (prt_raddr),
    .rdata (prt_rdata)
  );

  assign out_range_total = $signed(acc_r);

endmodule
